// ----- rtl/core/trc_pkg.sv -----
// Shared types, constants and the microprogram of the timer reload calibrator.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package trc_pkg;

    // Field and register widths.
    localparam int MEAS_W    = 16;
    localparam int TARGET_W  = 10;
    localparam int STEP_W    = 20;
    localparam int RELOAD_W  = 31;
    localparam int CFG_IDX_W = 2;

    // Shared multiplier and divider.
    localparam int MUL_A_W  = 31;
    localparam int MUL_B_W  = 16;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int DIV_W    = PROD_W;
    localparam int DIVR_W   = TARGET_W;
    localparam int DCNT_W   = $clog2(DIV_W + 1);
    localparam int STEPQ_W  = 18;   // step_size / 5 fits in 18 bits
    localparam int GROW_W   = STEP_W + MEAS_W;
    localparam int SHRINK_W = STEPQ_W + TARGET_W;

    // floor(step / 5) is taken as (step * ceil(2^22 / 5)) >> 22, which is exact
    // for every 20-bit step.
    localparam int                STEPQ_SH   = 22;
    localparam int                RECIP_W    = STEP_W + STEP_W;
    localparam logic [STEP_W-1:0] STEP_RECIP = 20'd838861;

    localparam logic [RELOAD_W-1:0] RELOAD_RESET = 31'd10000000;
    localparam logic [RELOAD_W-1:0] RELOAD_MAX   = 31'h7FFF_FFFF;
    localparam logic [DIVR_W-1:0]   STEP_DIVISOR = 10'd5;
    localparam logic [TARGET_W-1:0] TARGET_RESET = 10'd100;
    localparam logic [STEP_W-1:0]   STEP_RESET   = 20'd100000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP   = 2'd1;

    // Program counter and step labels.
    localparam int PC_W = 5;
    localparam logic [PC_W-1:0] S_IDLE        = 5'd0;
    localparam logic [PC_W-1:0] S_TEST_WIN    = 5'd1;
    localparam logic [PC_W-1:0] S_TEST_FAST   = 5'd2;
    localparam logic [PC_W-1:0] S_TEST_SLOW   = 5'd3;
    localparam logic [PC_W-1:0] S_SETTLE      = 5'd4;
    localparam logic [PC_W-1:0] S_GROW_MUL    = 5'd5;
    localparam logic [PC_W-1:0] S_GROW_WB     = 5'd6;
    localparam logic [PC_W-1:0] S_SHRINK_LD   = 5'd7;
    localparam logic [PC_W-1:0] S_SHRINK_MUL  = 5'd8;
    localparam logic [PC_W-1:0] S_SHRINK_WB   = 5'd9;
    localparam logic [PC_W-1:0] S_SCALE_TEST  = 5'd10;
    localparam logic [PC_W-1:0] S_SCALE_MUL   = 5'd11;
    localparam logic [PC_W-1:0] S_SCALE_LD    = 5'd12;
    localparam logic [PC_W-1:0] S_SCALE_DIV   = 5'd13;
    localparam logic [PC_W-1:0] S_SCALE_WB    = 5'd14;
    localparam logic [PC_W-1:0] S_SAT_WB      = 5'd15;
    localparam logic [PC_W-1:0] S_EMIT        = 5'd16;
    localparam logic [PC_W-1:0] S_RETURN      = 5'd17;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_SETTLE,
        OP_MUL_GROW,
        OP_GROW_WB,
        OP_STEP_QUOT,
        OP_DIV_RUN,
        OP_MUL_SHRINK,
        OP_SHRINK_WB,
        OP_MUL_SCALE,
        OP_DIV_SCALE_LD,
        OP_SCALE_WB,
        OP_SAT_WB,
        OP_EMIT
    } op_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_OUTSIDE,
        C_FAST,
        C_SLOW,
        C_TZERO,
        C_DIV_BUSY,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic outside;
        logic fast;
        logic slow;
        logic t_zero;
        logic div_busy;
        logic out_busy;
    } status_t;

    // Microprogram: a taken condition jumps to target, otherwise the step after.
    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: S_IDLE};
        unique case (pc)
            S_IDLE:       w = '{op: OP_LOAD,         cond: C_NO_IN,    target: S_IDLE};
            S_TEST_WIN:   w = '{op: OP_NOP,          cond: C_OUTSIDE,  target: S_SCALE_TEST};
            S_TEST_FAST:  w = '{op: OP_NOP,          cond: C_FAST,     target: S_GROW_MUL};
            S_TEST_SLOW:  w = '{op: OP_NOP,          cond: C_SLOW,     target: S_SHRINK_LD};
            S_SETTLE:     w = '{op: OP_SETTLE,       cond: C_ALWAYS,   target: S_EMIT};
            S_GROW_MUL:   w = '{op: OP_MUL_GROW,     cond: C_NEVER,    target: S_IDLE};
            S_GROW_WB:    w = '{op: OP_GROW_WB,      cond: C_ALWAYS,   target: S_EMIT};
            S_SHRINK_LD:  w = '{op: OP_STEP_QUOT,    cond: C_NEVER,    target: S_IDLE};
            S_SHRINK_MUL: w = '{op: OP_MUL_SHRINK,   cond: C_NEVER,    target: S_IDLE};
            S_SHRINK_WB:  w = '{op: OP_SHRINK_WB,    cond: C_ALWAYS,   target: S_EMIT};
            S_SCALE_TEST: w = '{op: OP_NOP,          cond: C_TZERO,    target: S_SAT_WB};
            S_SCALE_MUL:  w = '{op: OP_MUL_SCALE,    cond: C_NEVER,    target: S_IDLE};
            S_SCALE_LD:   w = '{op: OP_DIV_SCALE_LD, cond: C_NEVER,    target: S_IDLE};
            S_SCALE_DIV:  w = '{op: OP_DIV_RUN,      cond: C_DIV_BUSY, target: S_SCALE_DIV};
            S_SCALE_WB:   w = '{op: OP_SCALE_WB,     cond: C_ALWAYS,   target: S_EMIT};
            S_SAT_WB:     w = '{op: OP_SAT_WB,       cond: C_NEVER,    target: S_IDLE};
            S_EMIT:       w = '{op: OP_EMIT,         cond: C_OUT_BUSY, target: S_EMIT};
            S_RETURN:     w = '{op: OP_NOP,          cond: C_ALWAYS,   target: S_IDLE};
            default:      w = '{op: OP_NOP,          cond: C_ALWAYS,   target: S_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/timer_reload_calibrator.sv -----
// Timer reload calibrator: one result beat per measurement beat.
// An accepted measurement passes the window tests, then a settle, grow, shrink or scale
// step; a zero target saturates instead of scaling, and a scale runs the divider.
// After the result register is loaded, S_RETURN leads back to S_IDLE for the next input.
// Reset: asynchronous, active low; reload count 10000000, settle count 0, target 100,
// step size 100000, no result pending.
// Depends on trc_pkg, trc_seq and trc_dp.
`default_nettype none

module timer_reload_calibrator #(
    parameter int SETTLE_COUNT = 5
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [trc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [trc_pkg::STEP_W-1:0]     cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [trc_pkg::MEAS_W-1:0]     measured_rate,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [trc_pkg::RELOAD_W-1:0]   reload_count,
    output logic                                reload_changed,
    output logic                                settled,
    output logic                                saturated
);
    import trc_pkg::*;

    logic [TARGET_W-1:0] target_reg;
    logic [STEP_W-1:0]   step_reg;
    op_t                 op;
    status_t             status;
    logic                in_fire;

    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TARGET_RESET;
            step_reg   <= STEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_TARGET)
            begin
                target_reg <= cfg_data[TARGET_W-1:0];
            end
            else if (cfg_index == REG_STEP)
            begin
                step_reg <= cfg_data;
            end
        end
    end

    trc_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .op       (op),
        .in_ready (in_ready)
    );

    trc_dp #(
        .SETTLE_COUNT (SETTLE_COUNT)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .op             (op),
        .in_fire        (in_fire),
        .measured_rate  (measured_rate),
        .target         (target_reg),
        .step           (step_reg),
        .out_ready      (out_ready),
        .status         (status),
        .out_valid      (out_valid),
        .reload_count   (reload_count),
        .reload_changed (reload_changed),
        .settled        (settled),
        .saturated      (saturated)
    );

endmodule

`default_nettype wire

// ----- rtl/core/trc_div.sv -----
// Restoring divider that produces one quotient bit per cycle while run is high.
// Depends on trc_pkg for its widths.
`default_nettype none

module trc_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        load,
    input  wire logic                        run,
    input  wire logic [trc_pkg::DIV_W-1:0]   dividend,
    input  wire logic [trc_pkg::DIVR_W-1:0]  divisor,
    input  wire logic [trc_pkg::DCNT_W-1:0]  iters,
    output logic      [trc_pkg::DIV_W-1:0]   quotient,
    output logic                             busy
);
    import trc_pkg::*;

    logic [DIV_W-1:0]  quo_reg;
    logic [DIVR_W-1:0] rem_reg;
    logic [DIVR_W-1:0] dsr_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic [DIVR_W:0]   trial;
    logic              fits;

    // The dividend shifts out at the top as quotient bits enter at the bottom, so once
    // iters equals DIV_W the whole register holds the quotient.
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};
    assign busy  = cnt_reg != '0;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= iters;
        end
        else if (run && busy)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (run && busy)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? DIVR_W'(trial - {1'b0, dsr_reg}) : trial[DIVR_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/trc_seq.sv -----
// Microprogram sequencer: step counter, control store and jump logic.
// Depends on trc_pkg for the control word, status struct and program.
`default_nettype none

module trc_seq (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire trc_pkg::status_t status,
    output trc_pkg::op_t          op,
    output logic                  in_ready
);
    import trc_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    uword_t          uw;
    logic            take;

    assign uw       = ucode(pc_reg);
    assign op       = uw.op;
    assign in_ready = pc_reg == S_IDLE;

    always_comb
    begin
        unique case (uw.cond)
            C_NEVER:    take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_IN:    take = !in_valid;
            C_OUTSIDE:  take = status.outside;
            C_FAST:     take = status.fast;
            C_SLOW:     take = status.slow;
            C_TZERO:    take = status.t_zero;
            C_DIV_BUSY: take = status.div_busy;
            C_OUT_BUSY: take = status.out_busy;
            default:    take = 1'b1;
        endcase
        pc_next = take ? uw.target : PC_W'(pc_reg + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/trc_dp.sv -----
// Datapath: window compares, shared multiplier, divider, reload state and output register.
// Depends on trc_pkg and instantiates trc_div.
`default_nettype none

module trc_dp #(
    parameter int SETTLE_COUNT = 5
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire trc_pkg::op_t                  op,
    input  wire logic                          in_fire,
    input  wire logic [trc_pkg::MEAS_W-1:0]    measured_rate,
    input  wire logic [trc_pkg::TARGET_W-1:0]  target,
    input  wire logic [trc_pkg::STEP_W-1:0]    step,
    input  wire logic                          out_ready,
    output trc_pkg::status_t                   status,
    output logic                               out_valid,
    output logic      [trc_pkg::RELOAD_W-1:0]  reload_count,
    output logic                               reload_changed,
    output logic                               settled,
    output logic                               saturated
);
    import trc_pkg::*;

    localparam int SC_W = $clog2(SETTLE_COUNT + 1);

    logic [MEAS_W-1:0]   meas_reg;
    logic [RELOAD_W-1:0] reload_reg, reload_next;
    logic [SC_W-1:0]     settle_reg, settle_next;
    logic                changed_reg, changed_next;
    logic                done_reg, done_next;
    logic                sat_reg, sat_next;
    logic [PROD_W-1:0]   prod_reg;
    logic [STEPQ_W-1:0]  stepq_reg;
    logic [RECIP_W-1:0]  stepq_prod;
    logic                out_valid_reg;
    logic [RELOAD_W-1:0] out_count_reg;
    logic                out_changed_reg, out_done_reg, out_sat_reg;

    logic [19:0] m10;
    logic [20:0] m20;
    logic [13:0] t9, t11;
    logic [14:0] t19, t21;
    logic        in_win;
    logic        out_busy;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;

    logic               div_load, div_run, div_busy;
    logic [DIV_W-1:0]   div_dividend, div_quo;
    logic [DIVR_W-1:0]  div_divisor;
    logic [DCNT_W-1:0]  div_iters;

    logic [RELOAD_W+6:0]  grow_sum;
    logic [SHRINK_W-1:0]  dec;
    logic [SC_W:0]        settle_inc;

    // Window tests as exact cross-multiplied compares built from shifts.
    assign m10 = ({4'b0, meas_reg} << 3) + ({4'b0, meas_reg} << 1);
    assign m20 = {m10, 1'b0};
    assign t9  = ({4'b0, target} << 3) + {4'b0, target};
    assign t11 = ({4'b0, target} << 3) + ({4'b0, target} << 1) + {4'b0, target};
    assign t21 = ({5'b0, target} << 4) + ({5'b0, target} << 2) + {5'b0, target};
    assign t19 = ({5'b0, target} << 4) + ({5'b0, target} << 1) + {5'b0, target};

    assign in_win   = (m10 >= {6'b0, t9}) && (m10 <= {6'b0, t11});
    assign out_busy = out_valid_reg && !out_ready;

    assign status.outside  = !in_win;
    assign status.fast     = m20 > {6'b0, t21};
    assign status.slow     = m20 < {6'b0, t19};
    assign status.t_zero   = target == '0;
    assign status.div_busy = div_busy;
    assign status.out_busy = out_busy;

    // The step size is divided by five through a multiply by its reciprocal.
    assign stepq_prod = {{STEP_W{1'b0}}, step} * {{STEP_W{1'b0}}, STEP_RECIP};

    // Operand selection for the one shared multiplier.
    always_comb
    begin
        case (op)
            OP_MUL_GROW:
            begin
                mul_a = {{(MUL_A_W-STEP_W){1'b0}}, step};
                mul_b = meas_reg - {{(MEAS_W-TARGET_W){1'b0}}, target};
            end
            OP_MUL_SHRINK:
            begin
                mul_a = {{(MUL_A_W-STEPQ_W){1'b0}}, stepq_reg};
                mul_b = {{(MUL_B_W-TARGET_W){1'b0}}, target - meas_reg[TARGET_W-1:0]};
            end
            default:
            begin
                mul_a = reload_reg;
                mul_b = meas_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (op == OP_MUL_GROW || op == OP_MUL_SHRINK || op == OP_MUL_SCALE)
        begin
            prod_reg <= {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};
        end
        if (op == OP_STEP_QUOT)
        begin
            stepq_reg <= stepq_prod[STEPQ_SH +: STEPQ_W];
        end
        if (in_fire)
        begin
            meas_reg <= measured_rate;
        end
    end

    // Only the scale path divides; the divisor is the target rate.
    assign div_load     = op == OP_DIV_SCALE_LD;
    assign div_run      = op == OP_DIV_RUN;
    assign div_dividend = prod_reg;
    assign div_divisor  = target;
    assign div_iters    = DCNT_W'(DIV_W);

    trc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (div_load),
        .run      (div_run),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .iters    (div_iters),
        .quotient (div_quo),
        .busy     (div_busy)
    );

    assign grow_sum   = {7'b0, reload_reg} + {{(RELOAD_W+7-GROW_W){1'b0}}, prod_reg[GROW_W-1:0]};
    assign dec        = prod_reg[SHRINK_W-1:0];
    assign settle_inc = {1'b0, settle_reg} + 1'b1;

    always_comb
    begin
        reload_next  = reload_reg;
        settle_next  = settle_reg;
        changed_next = changed_reg;
        done_next    = done_reg;
        sat_next     = sat_reg;
        case (op)
            OP_LOAD:
            begin
                if (in_fire)
                begin
                    changed_next = 1'b0;
                    done_next    = 1'b0;
                    sat_next     = 1'b0;
                end
            end
            OP_SETTLE:
            begin
                if (settle_inc >= (SC_W+1)'(SETTLE_COUNT))
                begin
                    settle_next = '0;
                    done_next   = 1'b1;
                end
                else
                begin
                    settle_next = settle_inc[SC_W-1:0];
                end
            end
            OP_GROW_WB:
            begin
                changed_next = 1'b1;
                if (grow_sum[RELOAD_W+6:RELOAD_W] != '0)
                begin
                    reload_next = RELOAD_MAX;
                    sat_next    = 1'b1;
                end
                else
                begin
                    reload_next = grow_sum[RELOAD_W-1:0];
                end
            end
            OP_SHRINK_WB:
            begin
                changed_next = 1'b1;
                // An overshoot below zero restarts from the reset count.
                if ({{(RELOAD_W-SHRINK_W){1'b0}}, dec} > reload_reg)
                begin
                    reload_next = RELOAD_RESET;
                end
                else
                begin
                    reload_next = reload_reg - {{(RELOAD_W-SHRINK_W){1'b0}}, dec};
                end
            end
            OP_SCALE_WB:
            begin
                changed_next = 1'b1;
                if (div_quo[DIV_W-1:RELOAD_W] != '0)
                begin
                    reload_next = RELOAD_MAX;
                    sat_next    = 1'b1;
                end
                else
                begin
                    reload_next = div_quo[RELOAD_W-1:0];
                end
            end
            OP_SAT_WB:
            begin
                changed_next = 1'b1;
                reload_next  = RELOAD_MAX;
                sat_next     = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg    <= RELOAD_RESET;
            settle_reg    <= '0;
            changed_reg   <= 1'b0;
            done_reg      <= 1'b0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            reload_reg  <= reload_next;
            settle_reg  <= settle_next;
            changed_reg <= changed_next;
            done_reg    <= done_next;
            sat_reg     <= sat_next;
            if (op == OP_EMIT && !out_busy)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The result beat waits here while the next measurement is worked on.
    always_ff @(posedge clk)
    begin
        if (op == OP_EMIT && !out_busy)
        begin
            out_count_reg   <= reload_reg;
            out_changed_reg <= changed_reg;
            out_done_reg    <= done_reg;
            out_sat_reg     <= sat_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign reload_count   = out_count_reg;
    assign reload_changed = out_changed_reg;
    assign settled        = out_done_reg;
    assign saturated      = out_sat_reg;

    a_wb_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_SCALE_WB || op == OP_MUL_SHRINK) |-> !div_busy)
        else $error("writeback used the divider before it finished");

    a_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_EMIT) |-> !(done_reg && changed_reg))
        else $error("one beat both settled and rewrote the reload count");

    a_sat_changed: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_EMIT) |-> (!sat_reg || changed_reg))
        else $error("saturation flagged without a rewrite");

    a_settle_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_SETTLE && settle_reg == SC_W'(SETTLE_COUNT - 1)) |=>
        (settle_reg == '0 && done_reg))
        else $error("settle counter did not wrap on completion");

endmodule

`default_nettype wire
